// ----- src/ale_pkg.sv -----
// Package with the shared types and constants of the array list engine.
`default_nettype none

package ale_pkg;

    localparam int DEPTH_DEF = 16;

    typedef enum logic [2:0] {
        CMD_INS_FRONT = 3'd0,
        CMD_INS_BACK  = 3'd1,
        CMD_DEL_FRONT = 3'd2,
        CMD_DEL_BACK  = 3'd3,
        CMD_INS_AFTER = 3'd4,
        CMD_MAX       = 3'd5,
        CMD_DUMP      = 3'd6
    } cmd_t;

    typedef enum logic [1:0] {
        STAT_OK    = 2'd0,
        STAT_FULL  = 2'd1,
        STAT_EMPTY = 2'd2,
        STAT_NOKEY = 2'd3
    } status_t;

    typedef enum logic [2:0] {
        S_IDLE,
        S_SEARCH,
        S_MAX,
        S_UP,
        S_DOWN,
        S_DUMP_RD,
        S_DUMP_LD,
        S_RESP
    } state_t;

endpackage

`default_nettype wire

// ----- src/array_list_engine.sv -----
// Top level of the array list engine: sequencer, entry store and result register.
// Insert back, delete back, unused codes, rejections and front or back evictions need no
// walk; insert front, delete front, find max, insert after key and dump walk the store.
// One item at a time; the single read port of the entry store, stepped one address per
// cycle (one per result in a dump), sets every walk.
// Reset clears the count, the policy and the sequencer; store contents stay undefined.
`default_nettype none

module array_list_engine
    import ale_pkg::*;
#(
    parameter int DEPTH = DEPTH_DEF,
    localparam int CW = $clog2(DEPTH + 1)
)
(
    input  wire logic                 clk,
    input  wire logic                 rst_n,

    input  wire logic                 cfg_valid,
    output      logic                 cfg_ready,
    input  wire logic                 cfg_data,

    input  wire logic                 in_valid,
    output      logic                 in_ready,
    input  wire logic [2:0]           cmd,
    input  wire logic signed [31:0]   value,
    input  wire logic signed [31:0]   key,

    output      logic                 out_valid,
    input  wire logic                 out_ready,
    output      logic [1:0]           status,
    output      logic signed [31:0]   data,
    output      logic [CW-1:0]        count,
    output      logic                 last
);

    // Address width of the entry store; a single-entry store still gets one bit.
    localparam int AW = (DEPTH > 1) ? $clog2(DEPTH) : 1;
    localparam logic [CW-1:0] FULL_CNT = CW'(DEPTH);
    localparam logic [AW-1:0] LAST_IDX = AW'(DEPTH - 1);

    // The list lives in a single-port-read, single-port-write store. Position 0 is
    // the front. Shifts move one entry per cycle: a read is issued, and its data
    // is written one place over in the following cycle while the next read issues.
    logic [31:0]        entry_mem [DEPTH];
    logic [31:0]        rd_data_reg;
    logic               mem_we;
    logic [AW-1:0]      mem_waddr;
    logic [31:0]        mem_wdata;
    logic [AW-1:0]      mem_raddr;

    state_t             state_reg, state_next;
    logic [CW-1:0]      cnt_reg, cnt_next;
    logic [CW-1:0]      ptr_reg, ptr_next;
    logic [CW-1:0]      pos_reg, pos_next;
    logic               rv_reg, rv_next;
    logic [AW-1:0]      ra_reg, ra_next;
    logic signed [31:0] best_reg, best_next;
    logic [31:0]        op_val_reg, op_val_next;
    logic [31:0]        op_key_reg, op_key_next;
    status_t            status_reg, status_next;
    logic signed [31:0] data_reg, data_next;
    logic               last_reg, last_next;
    logic               pol_reg;

    logic               is_full;
    logic               is_empty;
    logic [CW-1:0]      ptr_m1;
    logic [CW-1:0]      ptr_p1;

    assign is_full  = (cnt_reg == FULL_CNT);
    assign is_empty = (cnt_reg == '0);
    assign ptr_m1   = ptr_reg - CW'(1);
    assign ptr_p1   = ptr_reg + CW'(1);

    // Configuration must be written only while the block is idle; the block does not enforce
    // this. The port is always ready; the policy bit takes effect on the next transaction.
    assign cfg_ready = 1'b1;

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            pol_reg <= 1'b0;
        end
        else if (cfg_valid)
        begin
            pol_reg <= cfg_data;
        end
    end

    // Entry store with a registered read port.
    always_ff @(posedge clk)
    begin
        if (mem_we)
        begin
            entry_mem[mem_waddr] <= mem_wdata;
        end
        rd_data_reg <= entry_mem[mem_raddr];
    end

    // Control state is reset; the operand, scan and result payload registers are not.
    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            state_reg <= S_IDLE;
            cnt_reg   <= '0;
            ptr_reg   <= '0;
            rv_reg    <= 1'b0;
            last_reg  <= 1'b1;
        end
        else
        begin
            state_reg <= state_next;
            cnt_reg   <= cnt_next;
            ptr_reg   <= ptr_next;
            rv_reg    <= rv_next;
            last_reg  <= last_next;
        end
    end

    always_ff @(posedge clk)
    begin
        pos_reg    <= pos_next;
        ra_reg     <= ra_next;
        best_reg   <= best_next;
        op_val_reg <= op_val_next;
        op_key_reg <= op_key_next;
        status_reg <= status_next;
        data_reg   <= data_next;
    end

    // Sequencer. ptr_reg walks the store; rv_reg marks that rd_data_reg holds the
    // entry at ra_reg, read in the previous cycle.
    always_comb
    begin
        state_next  = state_reg;
        cnt_next    = cnt_reg;
        ptr_next    = ptr_reg;
        pos_next    = pos_reg;
        rv_next     = 1'b0;
        ra_next     = ra_reg;
        best_next   = best_reg;
        op_val_next = op_val_reg;
        op_key_next = op_key_reg;
        status_next = status_reg;
        data_next   = data_reg;
        last_next   = last_reg;
        mem_we      = 1'b0;
        mem_waddr   = '0;
        mem_wdata   = op_val_reg;
        mem_raddr   = ptr_reg[AW-1:0];

        unique case (state_reg)
            S_IDLE:
            begin
                if (in_valid)
                begin
                    op_val_next = value;
                    op_key_next = key;
                    status_next = STAT_OK;
                    data_next   = '0;
                    last_next   = 1'b1;
                    ptr_next    = '0;
                    state_next  = S_RESP;
                    unique case (cmd_t'(cmd))
                        CMD_INS_FRONT:
                        begin
                            if (is_full)
                            begin
                                // Evicting the front and inserting at the front
                                // amounts to overwriting the front entry.
                                if (!pol_reg)
                                begin
                                    status_next = STAT_FULL;
                                end
                                else
                                begin
                                    mem_we    = 1'b1;
                                    mem_waddr = '0;
                                    mem_wdata = value;
                                end
                            end
                            else
                            begin
                                ptr_next   = cnt_reg;
                                pos_next   = '0;
                                state_next = S_UP;
                            end
                        end
                        CMD_INS_BACK:
                        begin
                            if (is_full)
                            begin
                                if (!pol_reg)
                                begin
                                    status_next = STAT_FULL;
                                end
                                else
                                begin
                                    mem_we    = 1'b1;
                                    mem_waddr = LAST_IDX;
                                    mem_wdata = value;
                                end
                            end
                            else
                            begin
                                mem_we    = 1'b1;
                                mem_waddr = cnt_reg[AW-1:0];
                                mem_wdata = value;
                                cnt_next  = cnt_reg + CW'(1);
                            end
                        end
                        CMD_DEL_FRONT:
                        begin
                            if (is_empty)
                            begin
                                status_next = STAT_EMPTY;
                            end
                            else
                            begin
                                ptr_next   = CW'(1);
                                state_next = S_DOWN;
                            end
                        end
                        CMD_DEL_BACK:
                        begin
                            if (is_empty)
                            begin
                                status_next = STAT_EMPTY;
                            end
                            else
                            begin
                                cnt_next = cnt_reg - CW'(1);
                            end
                        end
                        CMD_INS_AFTER:
                        begin
                            if (is_full && !pol_reg)
                            begin
                                status_next = STAT_FULL;
                            end
                            else
                            begin
                                // The back eviction stands even if the key is
                                // not found later.
                                if (is_full)
                                begin
                                    cnt_next = cnt_reg - CW'(1);
                                end
                                state_next = S_SEARCH;
                            end
                        end
                        CMD_MAX:
                        begin
                            if (is_empty)
                            begin
                                status_next = STAT_EMPTY;
                            end
                            else
                            begin
                                state_next = S_MAX;
                            end
                        end
                        CMD_DUMP:
                        begin
                            if (is_empty)
                            begin
                                status_next = STAT_EMPTY;
                            end
                            else
                            begin
                                state_next = S_DUMP_RD;
                            end
                        end
                        default:
                        begin
                            // The unused code reports the count and changes nothing.
                        end
                    endcase
                end
            end

            S_SEARCH:
            begin
                if (rv_reg && (rd_data_reg == op_key_reg))
                begin
                    // First match: open a gap right after it. A read still in
                    // flight is dropped.
                    pos_next   = CW'(ra_reg) + CW'(1);
                    ptr_next   = cnt_reg;
                    state_next = S_UP;
                end
                else if (ptr_reg < cnt_reg)
                begin
                    rv_next  = 1'b1;
                    ra_next  = ptr_reg[AW-1:0];
                    ptr_next = ptr_p1;
                end
                else if (!rv_reg)
                begin
                    status_next = STAT_NOKEY;
                    state_next  = S_RESP;
                end
            end

            S_MAX:
            begin
                if (rv_reg && ((ra_reg == '0) || ($signed(rd_data_reg) > best_reg)))
                begin
                    best_next = $signed(rd_data_reg);
                end
                if (ptr_reg < cnt_reg)
                begin
                    rv_next  = 1'b1;
                    ra_next  = ptr_reg[AW-1:0];
                    ptr_next = ptr_p1;
                end
                else if (!rv_reg)
                begin
                    data_next  = best_reg;
                    state_next = S_RESP;
                end
            end

            S_UP:
            begin
                if (rv_reg)
                begin
                    mem_we    = 1'b1;
                    mem_waddr = ra_reg + AW'(1);
                    mem_wdata = rd_data_reg;
                end
                if (ptr_reg > pos_reg)
                begin
                    mem_raddr = ptr_m1[AW-1:0];
                    rv_next   = 1'b1;
                    ra_next   = ptr_m1[AW-1:0];
                    ptr_next  = ptr_m1;
                end
                else if (!rv_reg)
                begin
                    mem_we     = 1'b1;
                    mem_waddr  = pos_reg[AW-1:0];
                    mem_wdata  = op_val_reg;
                    cnt_next   = cnt_reg + CW'(1);
                    state_next = S_RESP;
                end
            end

            S_DOWN:
            begin
                if (rv_reg)
                begin
                    mem_we    = 1'b1;
                    mem_waddr = ra_reg - AW'(1);
                    mem_wdata = rd_data_reg;
                end
                if (ptr_reg < cnt_reg)
                begin
                    rv_next  = 1'b1;
                    ra_next  = ptr_reg[AW-1:0];
                    ptr_next = ptr_p1;
                end
                else if (!rv_reg)
                begin
                    cnt_next   = cnt_reg - CW'(1);
                    state_next = S_RESP;
                end
            end

            S_DUMP_RD:
            begin
                state_next = S_DUMP_LD;
            end

            S_DUMP_LD:
            begin
                status_next = STAT_OK;
                data_next   = $signed(rd_data_reg);
                last_next   = (ptr_p1 == cnt_reg);
                ptr_next    = ptr_p1;
                state_next  = S_RESP;
            end

            S_RESP:
            begin
                if (out_ready)
                begin
                    state_next = last_reg ? S_IDLE : S_DUMP_RD;
                end
            end

            default:
            begin
                state_next = S_IDLE;
            end
        endcase
    end

    assign in_ready  = (state_reg == S_IDLE);
    assign out_valid = (state_reg == S_RESP);
    assign status    = status_reg;
    assign data      = data_reg;
    assign count     = cnt_reg;
    assign last      = last_reg;

    // The count never runs past the store depth.
    a_cnt_bound: assert property (@(posedge clk) disable iff (!rst_n)
        cnt_reg <= FULL_CNT)
        else $error("entry count exceeds depth");

    // A transaction is never taken while a result is pending.
    a_one_at_a_time: assert property (@(posedge clk) disable iff (!rst_n)
        !(in_ready && out_valid))
        else $error("input ready while a result is pending");

    // The final result of a run returns the block to idle.
    a_last_idle: assert property (@(posedge clk) disable iff (!rst_n)
        (out_valid && out_ready && last) |=> in_ready)
        else $error("block not idle after final result");

    // A rejected insert only happens on a full list.
    a_full_reject: assert property (@(posedge clk) disable iff (!rst_n)
        (out_valid && (status_reg == STAT_FULL)) |-> (cnt_reg == FULL_CNT))
        else $error("full rejection with room left");

endmodule

`default_nettype wire

// ----- tb/array_list_checker.sv -----
// Checker for the array list engine: mirrors the list, predicts each result and compares.
module array_list_checker
    import ale_pkg::*;
#(
    parameter int DEPTH = DEPTH_DEF,
    localparam int CW = $clog2(DEPTH + 1)
)
(
    input  wire logic                 clk,
    input  wire logic                 rst_n,
    input  wire logic                 cfg_valid,
    input  wire logic                 cfg_ready,
    input  wire logic                 cfg_data,
    input  wire logic                 in_valid,
    input  wire logic                 in_ready,
    input  wire logic [2:0]           cmd,
    input  wire logic signed [31:0]   value,
    input  wire logic signed [31:0]   key,
    input  wire logic                 out_valid,
    input  wire logic                 out_ready,
    input  wire logic [1:0]           status,
    input  wire logic signed [31:0]   data,
    input  wire logic [CW-1:0]        count,
    input  wire logic                 last,
    output int                        mismatch_count,
    output int                        results_awaited
);

    timeunit 1ns;
    timeprecision 1ps;

    typedef struct {
        logic [1:0]         status;
        logic signed [31:0] data;
        logic [CW-1:0]      count;
        logic               last;
    } list_result_t;

    // Mirror of the list contents, front at index 0.
    logic signed [31:0] list_words [DEPTH];
    int                 n_words = 0;
    logic               evict_policy = 1'b0;
    list_result_t       awaited_results [$];

    function automatic void note_result(logic [1:0] st, logic signed [31:0] d, logic fin);
        list_result_t r;
        r.status = st;
        r.data   = d;
        r.count  = n_words[CW-1:0];
        r.last   = fin;
        awaited_results.push_back(r);
    endfunction

    function automatic void remove_front();
        for (int i = 0; i + 1 < n_words; i++)
            list_words[i] = list_words[i + 1];
        n_words--;
    endfunction

    function automatic void remove_back();
        n_words--;
    endfunction

    function automatic void insert_at(int pos, logic signed [31:0] w);
        for (int i = n_words; i > pos; i--)
            list_words[i] = list_words[i - 1];
        list_words[pos] = w;
        n_words++;
    endfunction

    // Applies one command to the mirror and queues the results it should produce.
    function automatic void apply_list_cmd(logic [2:0] c, logic signed [31:0] v,
                                           logic signed [31:0] k);
        int                 hit;
        logic signed [31:0] best;
        hit = -1;
        case (c)
            CMD_INS_FRONT, CMD_INS_BACK, CMD_INS_AFTER:
            begin
                if (n_words >= DEPTH && !evict_policy)
                begin
                    note_result(STAT_FULL, '0, 1'b1);
                end
                else
                begin
                    if (n_words >= DEPTH)
                    begin
                        if (c == CMD_INS_FRONT)
                            remove_front();
                        else
                            remove_back();
                    end
                    if (c == CMD_INS_FRONT)
                    begin
                        insert_at(0, v);
                        note_result(STAT_OK, '0, 1'b1);
                    end
                    else if (c == CMD_INS_BACK)
                    begin
                        insert_at(n_words, v);
                        note_result(STAT_OK, '0, 1'b1);
                    end
                    else
                    begin
                        for (int i = 0; i < n_words; i++)
                            if (hit < 0 && list_words[i] == k)
                                hit = i;
                        if (hit < 0)
                            note_result(STAT_NOKEY, '0, 1'b1);
                        else
                        begin
                            insert_at(hit + 1, v);
                            note_result(STAT_OK, '0, 1'b1);
                        end
                    end
                end
            end
            CMD_DEL_FRONT, CMD_DEL_BACK:
            begin
                if (n_words == 0)
                    note_result(STAT_EMPTY, '0, 1'b1);
                else
                begin
                    if (c == CMD_DEL_FRONT)
                        remove_front();
                    else
                        remove_back();
                    note_result(STAT_OK, '0, 1'b1);
                end
            end
            CMD_MAX:
            begin
                if (n_words == 0)
                    note_result(STAT_EMPTY, '0, 1'b1);
                else
                begin
                    best = list_words[0];
                    for (int i = 1; i < n_words; i++)
                        if (list_words[i] > best)
                            best = list_words[i];
                    note_result(STAT_OK, best, 1'b1);
                end
            end
            CMD_DUMP:
            begin
                if (n_words == 0)
                    note_result(STAT_EMPTY, '0, 1'b1);
                else
                    for (int i = 0; i < n_words; i++)
                        note_result(STAT_OK, list_words[i], i == n_words - 1);
            end
            default:
            begin
                note_result(STAT_OK, '0, 1'b1);
            end
        endcase
    endfunction

    always @(posedge clk)
    begin
        list_result_t want;
        if (!rst_n)
        begin
            n_words      = 0;
            evict_policy = 1'b0;
            awaited_results.delete();
        end
        else
        begin
            if (out_valid && out_ready)
            begin
                if (awaited_results.size() == 0)
                begin
                    $error("unexpected result: status %0d data %0d count %0d last %0d",
                           status, data, count, last);
                    mismatch_count++;
                end
                else
                begin
                    want = awaited_results.pop_front();
                    if (status !== want.status)
                    begin
                        $error("status: expected %0d, actual %0d", want.status, status);
                        mismatch_count++;
                    end
                    if (data !== want.data)
                    begin
                        $error("data: expected %0d, actual %0d", want.data, data);
                        mismatch_count++;
                    end
                    if (count !== want.count)
                    begin
                        $error("count: expected %0d, actual %0d", want.count, count);
                        mismatch_count++;
                    end
                    if (last !== want.last)
                    begin
                        $error("last: expected %0d, actual %0d", want.last, last);
                        mismatch_count++;
                    end
                end
            end
            if (cfg_valid && cfg_ready)
                evict_policy = cfg_data;
            if (in_valid && in_ready)
                apply_list_cmd(cmd, value, key);
        end
        results_awaited = awaited_results.size();
    end

endmodule

// ----- tb/tb_array_list_engine.sv -----
// Testbench top for the array list engine: clock, reset, stimulus, flow control and verdict.
module tb_array_list_engine;

    timeunit 1ns;
    timeprecision 1ps;

    import ale_pkg::*;

    localparam int CW = $clog2(DEPTH_DEF + 1);

    // Command code that the engine does not define; it must still answer once.
    localparam logic [2:0] CMD_UNUSED = 3'd7;

    // Cycles allowed for the engine to settle after its last result. The
    // longest walk is a dump of a full list.
    localparam int DRAIN_CYCLES = 64;

    // A run is declared hung after this many cycles without any transaction.
    // The longest legal quiet stretch is the long receiver hold plus one walk.
    localparam int WATCHDOG_LIMIT = 2000;

    // Length of the deliberate receiver hold that backs the engine up.
    localparam int HOLD_CYCLES = 200;

    logic                 clk;
    logic                 rst_n;
    logic                 cfg_valid;
    logic                 cfg_ready;
    logic                 cfg_data;
    logic                 in_valid;
    logic                 in_ready;
    logic [2:0]           cmd;
    logic signed [31:0]   value;
    logic signed [31:0]   key;
    logic                 out_valid;
    logic                 out_ready;
    logic [1:0]           status;
    logic signed [31:0]   data;
    logic [CW-1:0]        count;
    logic                 last;

    int                   mismatch_count;
    int                   results_awaited;

    // Random gaps on both channels are allowed while this is set.
    bit                   gaps_enabled = 1'b1;
    // Set by the stimulus to ask the receiver for one long hold.
    bit                   hold_request = 1'b0;

    array_list_engine dut (
        .clk       (clk),
        .rst_n     (rst_n),
        .cfg_valid (cfg_valid),
        .cfg_ready (cfg_ready),
        .cfg_data  (cfg_data),
        .in_valid  (in_valid),
        .in_ready  (in_ready),
        .cmd       (cmd),
        .value     (value),
        .key       (key),
        .out_valid (out_valid),
        .out_ready (out_ready),
        .status    (status),
        .data      (data),
        .count     (count),
        .last      (last)
    );

    array_list_checker list_checker (
        .clk             (clk),
        .rst_n           (rst_n),
        .cfg_valid       (cfg_valid),
        .cfg_ready       (cfg_ready),
        .cfg_data        (cfg_data),
        .in_valid        (in_valid),
        .in_ready        (in_ready),
        .cmd             (cmd),
        .value           (value),
        .key             (key),
        .out_valid       (out_valid),
        .out_ready       (out_ready),
        .status          (status),
        .data            (data),
        .count           (count),
        .last            (last),
        .mismatch_count  (mismatch_count),
        .results_awaited (results_awaited)
    );

    initial
    begin
        clk = 1'b0;
        forever #2 clk = ~clk;
    end

    // Every input sits at a known value from time zero. All driving happens
    // on the falling edge so that the engine and the checker both see stable
    // values at the rising edge.
    initial
    begin
        rst_n     = 1'b0;
        cfg_valid = 1'b0;
        cfg_data  = 1'b0;
        in_valid  = 1'b0;
        cmd       = '0;
        value     = '0;
        key       = '0;
        out_ready = 1'b0;
    end

    // Offers one command transaction. A random gap may come first; when no gap
    // is taken, valid simply stays high from the previous transaction.
    task automatic offer_item(input logic [2:0] c, input logic signed [31:0] v,
                              input logic signed [31:0] k);
        int gap;
        gap = (gaps_enabled && $urandom_range(0, 3) == 0) ? $urandom_range(1, 7) : 0;
        @(negedge clk);
        if (gap > 0)
        begin
            in_valid = 1'b0;
            repeat (gap) @(negedge clk);
        end
        in_valid = 1'b1;
        cmd      = c;
        value    = v;
        key      = k;
        do @(posedge clk); while (!in_ready);
    endtask

    // Drops the command valid and waits until every predicted result has come
    // back, then gives the engine time to finish any walk still in progress.
    task automatic drain_engine();
        @(negedge clk);
        in_valid = 1'b0;
        while (results_awaited != 0)
            @(posedge clk);
        repeat (DRAIN_CYCLES) @(posedge clk);
    endtask

    // The policy register is only ever written while the engine is idle.
    task automatic write_full_policy(input logic evict);
        drain_engine();
        @(negedge clk);
        cfg_valid = 1'b1;
        cfg_data  = evict;
        do @(posedge clk); while (!cfg_ready);
        @(negedge clk);
        cfg_valid = 1'b0;
    endtask

    // Words come mostly from a small pool so that keys hit, duplicates appear
    // and the first-match rule of insert-after gets exercised; the rest are
    // the signed extremes and fully random words.
    function automatic logic signed [31:0] pick_word();
        int r;
        r = $urandom_range(0, 9);
        if (r < 6)
        begin
            case ($urandom_range(0, 5))
                0: return 32'sd5;
                1: return -32'sd5;
                2: return 32'sd100;
                3: return -32'sd100;
                4: return 32'sd0;
                default: return 32'sd7;
            endcase
        end
        else if (r == 6)
        begin
            case ($urandom_range(0, 3))
                0: return 32'h7FFF_FFFF;
                1: return 32'h8000_0000;
                2: return 32'hFFFF_FFFF;
                default: return 32'h0000_0001;
            endcase
        end
        return $urandom;
    endfunction

    // Inserts are drawn with the given percentage so a phase can push the
    // list toward full or toward empty.
    function automatic logic [2:0] pick_cmd(input int grow_pct);
        if ($urandom_range(0, 99) < grow_pct)
        begin
            case ($urandom_range(0, 2))
                0: return CMD_INS_FRONT;
                1: return CMD_INS_BACK;
                default: return CMD_INS_AFTER;
            endcase
        end
        case ($urandom_range(0, 9))
            0, 1, 2: return CMD_DEL_FRONT;
            3, 4, 5: return CMD_DEL_BACK;
            6, 7: return CMD_MAX;
            8: return CMD_DUMP;
            default: return ($urandom_range(0, 1) == 0) ? CMD_UNUSED : CMD_DUMP;
        endcase
    endfunction

    task automatic run_random_phase(input int n_items, input int grow_pct);
        for (int i = 0; i < n_items; i++)
            offer_item(pick_cmd(grow_pct), pick_word(), pick_word());
    endtask

    // Receiver: random stalls, one long hold on request, and none at the end.
    initial
    begin
        wait (rst_n === 1'b1);
        forever
        begin
            @(negedge clk);
            if (hold_request)
            begin
                out_ready = 1'b0;
                repeat (HOLD_CYCLES) @(negedge clk);
                hold_request = 1'b0;
            end
            else if (gaps_enabled && $urandom_range(0, 3) == 0)
            begin
                out_ready = 1'b0;
                repeat ($urandom_range(1, 7)) @(negedge clk);
            end
            else
            begin
                out_ready = 1'b1;
            end
        end
    end

    // Watchdog: any transaction on any channel restarts the count.
    initial
    begin
        int quiet;
        quiet = 0;
        while (quiet < WATCHDOG_LIMIT)
        begin
            @(posedge clk);
            if (!rst_n || (in_valid && in_ready) || (out_valid && out_ready)
                || (cfg_valid && cfg_ready))
                quiet = 0;
            else
                quiet++;
        end
        $display("[array_list_engine] ERROR");
        $finish;
    end

    initial
    begin
        repeat (4) @(negedge clk);
        rst_n = 1'b1;

        write_full_policy(1'b0);

        // Every command but the two plain inserts against an empty list, including the unused code.
        offer_item(CMD_DUMP, 32'sd0, 32'sd0);
        offer_item(CMD_MAX, 32'sd0, 32'sd0);
        offer_item(CMD_DEL_FRONT, 32'sd0, 32'sd0);
        offer_item(CMD_DEL_BACK, 32'sd0, 32'sd0);
        offer_item(CMD_INS_AFTER, 32'sd9, 32'sd0);
        offer_item(CMD_UNUSED, 32'hFFFF_FFFF, 32'hFFFF_FFFF);

        // Signed extremes: the largest word must win the maximum over the
        // smallest even though its raw bits compare lower.
        offer_item(CMD_INS_BACK, 32'h7FFF_FFFF, 32'sd0);
        offer_item(CMD_INS_FRONT, 32'h8000_0000, 32'sd0);
        offer_item(CMD_INS_AFTER, -32'sd1, 32'h8000_0000);
        offer_item(CMD_INS_AFTER, 32'sd3, 32'sd12345);
        offer_item(CMD_MAX, 32'sd0, 32'sd0);
        offer_item(CMD_DUMP, 32'sd0, 32'sd0);
        offer_item(CMD_DEL_FRONT, 32'sd0, 32'sd0);
        offer_item(CMD_DEL_BACK, 32'sd0, 32'sd0);
        offer_item(CMD_MAX, 32'sd0, 32'sd0);
        offer_item(CMD_DEL_BACK, 32'sd0, 32'sd0);

        // Fill the list, then try to grow it while inserts are rejected.
        for (int i = 0; i < DEPTH_DEF; i++)
            offer_item(CMD_INS_BACK, 32'sd1000 + i, 32'sd0);
        offer_item(CMD_INS_FRONT, 32'sd1, 32'sd0);
        offer_item(CMD_INS_AFTER, 32'sd2, 32'sd1000);

        // Eviction: the front goes for a front insert, the back otherwise.
        // An insert-after with an absent key still loses its back entry.
        write_full_policy(1'b1);
        offer_item(CMD_INS_FRONT, 32'sd11, 32'sd0);
        offer_item(CMD_INS_BACK, 32'sd22, 32'sd0);
        offer_item(CMD_INS_AFTER, 32'sd55, 32'sd999);
        offer_item(CMD_INS_BACK, 32'sd33, 32'sd0);
        offer_item(CMD_INS_AFTER, 32'sd44, 32'sd1005);
        offer_item(CMD_DUMP, 32'sd0, 32'sd0);

        // Random part. The first phase opens with a long receiver hold while
        // commands keep coming, so the engine backs up and stalls its input.
        write_full_policy(1'b0);
        hold_request = 1'b1;
        run_random_phase(70, 70);
        write_full_policy(1'b1);
        run_random_phase(70, 75);
        write_full_policy(1'b0);
        run_random_phase(60, 35);
        write_full_policy(1'b1);
        gaps_enabled = 1'b0;
        run_random_phase(60, 55);

        drain_engine();
        if (mismatch_count == 0)
            $display("[array_list_engine] OK");
        else
            $display("[array_list_engine] ERROR");
        $finish;
    end

endmodule
